FILE: sv/tes_pkg.sv
// ----------------------------------------------------------------------------
// Tick event scheduler package
// Shared types, codes and sizes for the periodic and one-shot timer block.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int TIME_W         = 32;
  localparam int HANDLE_W       = 8;
  localparam int PERIODIC_SLOTS = 8;
  localparam int ONESHOT_SLOTS  = 8;
  localparam int MAX_RESULTS    = 16;
  localparam int FCNT_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_REG_PER  = 3'd1,
    MODE_SET_EN   = 3'd2,
    MODE_REG_ONE  = 3'd3,
    MODE_CANCEL   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PERIODIC = 2'd0,
    KIND_ONESHOT  = 2'd1,
    KIND_ACK      = 2'd2
  } kind_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_INC,
    S_TICK_PER,
    S_TICK_ONE,
    S_TICK_END,
    S_REG_RELOAD,
    S_REG_DUE,
    S_ENA_WALK,
    S_ONE_ADD,
    S_ONE_CANCEL,
    S_ACK
  } state_e;

  typedef struct packed {
    logic [2:0]          mode;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   ticks;
    logic                enable;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] fired_handle;
    logic                status;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] add_a;
    logic [TIME_W-1:0] add_b;
    logic              cin;
    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              eq;
  } alu_rsp_t;

endpackage

FILE: sv/tes_alu.sv
// ----------------------------------------------------------------------------
// Tick event scheduler time unit
// The one adder and equality comparator on tick times, shared by every sequencer step that needs one.
// ----------------------------------------------------------------------------
module tes_alu (
  input  tes_pkg::alu_req_t req,
  output tes_pkg::alu_rsp_t rsp
);

  logic [tes_pkg::TIME_W:0] wide_sum;

  assign wide_sum = {1'b0, req.add_a} + {1'b0, req.add_b}
                  + {{tes_pkg::TIME_W{1'b0}}, req.cin};
  assign rsp.sum  = wide_sum[tes_pkg::TIME_W-1:0];
  assign rsp.eq   = (req.cmp_a == req.cmp_b);

endmodule

FILE: sv/tick_event_scheduler.sv
// ----------------------------------------------------------------------------
// Tick event scheduler
// Periodic and one-shot software timer driven by tick and command items.
// ----------------------------------------------------------------------------
// An item is taken on cmd when start is high and busy is low. A tick item
// advances the tick count and then reports every due enabled periodic slot,
// then every due one-shot slot, at most MAX_RESULTS in all, each as one
// result on result, flagged by strobe for one cycle; the final one carries
// last. A tick with nothing due gives no result. Every other item gives one
// acknowledge result with last. A sequencer walks the slots one per cycle
// through a single shared adder and comparator. A tick walks the registered
// periodic count and then all one-shot slots; registering a periodic slot
// sets its reload and then its due time, or goes straight to the acknowledge
// when the table is full, as does an unknown mode; enable, one-shot register
// and cancel walk at most the table size.
// Each fired result is held until the next one is found or the walk ends,
// so that the final one can carry last, and then leaves through an output
// register. The final result of every item is on result in the cycle in
// which busy falls, when a new item may already be taken.
// The receiver cannot stall; results are never held back.
// Reset clears the tick count, the periodic count, all enable and occupied
// flags and the one-shot handles, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module tick_event_scheduler #(
  parameter int PERIODIC_SLOTS = tes_pkg::PERIODIC_SLOTS,
  parameter int ONESHOT_SLOTS  = tes_pkg::ONESHOT_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tes_pkg::cmd_t    cmd,
  output logic             strobe,
  output tes_pkg::result_t result
);

  localparam int PIW  = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
  localparam int OIW  = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
  localparam int PCW  = $clog2(PERIODIC_SLOTS + 1);
  localparam int MAXS = (PERIODIC_SLOTS > ONESHOT_SLOTS) ? PERIODIC_SLOTS
                                                         : ONESHOT_SLOTS;
  localparam int CW   = $clog2(MAXS + 1);
  localparam int TW   = tes_pkg::TIME_W;
  localparam int HW   = tes_pkg::HANDLE_W;

  tes_pkg::state_e   state, state_next;
  tes_pkg::cmd_t     cmd_q;
  tes_pkg::alu_req_t alu_req;
  tes_pkg::alu_rsp_t alu_rsp;
  tes_pkg::result_t  result_next;

  logic [TW-1:0]  now;
  logic [PCW-1:0] count;
  logic [CW-1:0]  idx;
  logic           st;
  logic           strobe_next;

  logic [HW-1:0]  phandle [PERIODIC_SLOTS];
  logic [TW-1:0]  preload [PERIODIC_SLOTS];
  logic [TW-1:0]  pdue    [PERIODIC_SLOTS];
  logic           pen     [PERIODIC_SLOTS];
  logic [HW-1:0]  ohandle [ONESHOT_SLOTS];
  logic [TW-1:0]  odue    [ONESHOT_SLOTS];
  logic           occ     [ONESHOT_SLOTS];

  logic                   pend_valid;
  logic [1:0]             pend_kind;
  logic [HW-1:0]          pend_handle;
  logic [tes_pkg::FCNT_W-1:0] fcnt;

  logic [PIW-1:0] pi;
  logic [OIW-1:0] oi;
  logic           per_in, os_in;
  logic           fire, record;
  logic [1:0]     fire_kind;
  logic [HW-1:0]  fire_handle;

  tes_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign pi     = idx[PIW-1:0];
  assign oi     = idx[OIW-1:0];
  assign per_in = (idx < CW'(count));
  assign os_in  = (idx < CW'(ONESHOT_SLOTS));
  assign busy   = (state != tes_pkg::S_IDLE);

  always_comb begin
    alu_req.add_a = now;
    alu_req.add_b = cmd_q.ticks;
    alu_req.cin   = 1'b0;
    alu_req.cmp_a = now;
    alu_req.cmp_b = now;
    case (state)
      tes_pkg::S_TICK_INC: begin
        alu_req.add_b = '0;
        alu_req.cin   = 1'b1;
      end
      tes_pkg::S_TICK_PER: begin
        alu_req.add_b = preload[pi];
        alu_req.cmp_a = pdue[pi];
      end
      tes_pkg::S_TICK_ONE: begin
        alu_req.cmp_a = odue[oi];
      end
      tes_pkg::S_REG_RELOAD: begin
        alu_req.add_a = cmd_q.ticks;
        alu_req.add_b = '1;
      end
      tes_pkg::S_ENA_WALK: begin
        alu_req.add_b = preload[pi];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fire        = 1'b0;
    fire_kind   = tes_pkg::KIND_PERIODIC;
    fire_handle = phandle[pi];
    if (state == tes_pkg::S_TICK_PER) begin
      fire = per_in && pen[pi] && alu_rsp.eq;
    end else if (state == tes_pkg::S_TICK_ONE) begin
      fire        = os_in && occ[oi] && alu_rsp.eq;
      fire_kind   = tes_pkg::KIND_ONESHOT;
      fire_handle = ohandle[oi];
    end
  end

  assign record = fire && (fcnt < tes_pkg::FCNT_W'(tes_pkg::MAX_RESULTS));

  always_comb begin
    state_next  = state;
    strobe_next = 1'b0;
    result_next = '{kind: pend_kind, fired_handle: pend_handle,
                    status: tes_pkg::STATUS_OK, last: 1'b0};
    case (state)
      tes_pkg::S_IDLE: begin
        if (start) begin
          case (cmd.mode)
            tes_pkg::MODE_TICK:    state_next = tes_pkg::S_TICK_INC;
            tes_pkg::MODE_REG_PER: state_next = (count < PCW'(PERIODIC_SLOTS))
                                              ? tes_pkg::S_REG_RELOAD
                                              : tes_pkg::S_ACK;
            tes_pkg::MODE_SET_EN:  state_next = tes_pkg::S_ENA_WALK;
            tes_pkg::MODE_REG_ONE: state_next = tes_pkg::S_ONE_ADD;
            tes_pkg::MODE_CANCEL:  state_next = tes_pkg::S_ONE_CANCEL;
            default:               state_next = tes_pkg::S_ACK;
          endcase
        end
      end
      tes_pkg::S_TICK_INC: state_next = tes_pkg::S_TICK_PER;
      tes_pkg::S_TICK_PER: begin
        if (!per_in) begin
          state_next = tes_pkg::S_TICK_ONE;
        end
        strobe_next = record && pend_valid;
      end
      tes_pkg::S_TICK_ONE: begin
        if (!os_in) begin
          state_next = tes_pkg::S_TICK_END;
        end
        strobe_next = record && pend_valid;
      end
      tes_pkg::S_TICK_END: begin
        strobe_next      = pend_valid;
        result_next.last = 1'b1;
        state_next       = tes_pkg::S_IDLE;
      end
      tes_pkg::S_REG_RELOAD: state_next = tes_pkg::S_REG_DUE;
      tes_pkg::S_REG_DUE:    state_next = tes_pkg::S_ACK;
      tes_pkg::S_ENA_WALK: begin
        if (!per_in || (phandle[pi] == cmd_q.handle)) begin
          state_next = tes_pkg::S_ACK;
        end
      end
      tes_pkg::S_ONE_ADD: begin
        if (!os_in || !occ[oi]) begin
          state_next = tes_pkg::S_ACK;
        end
      end
      tes_pkg::S_ONE_CANCEL: begin
        if (!os_in || (ohandle[oi] == cmd_q.handle)) begin
          state_next = tes_pkg::S_ACK;
        end
      end
      tes_pkg::S_ACK: begin
        strobe_next = 1'b1;
        result_next = '{kind: tes_pkg::KIND_ACK, fired_handle: cmd_q.handle,
                        status: st, last: 1'b1};
        state_next  = tes_pkg::S_IDLE;
      end
      default: state_next = tes_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      now        <= '0;
      count      <= '0;
      idx        <= '0;
      st         <= tes_pkg::STATUS_FAIL;
      pend_valid <= 1'b0;
      fcnt       <= '0;
      for (int i = 0; i < PERIODIC_SLOTS; i++) begin
        pen[i] <= 1'b0;
      end
      for (int i = 0; i < ONESHOT_SLOTS; i++) begin
        occ[i]     <= 1'b0;
        ohandle[i] <= '0;
      end
    end else begin
      strobe <= strobe_next;
      case (state)
        tes_pkg::S_IDLE: begin
          idx        <= '0;
          st         <= tes_pkg::STATUS_FAIL;
          pend_valid <= 1'b0;
          fcnt       <= '0;
        end
        tes_pkg::S_TICK_INC: begin
          now <= alu_rsp.sum;
        end
        tes_pkg::S_TICK_PER: begin
          idx <= per_in ? idx + CW'(1) : '0;
        end
        tes_pkg::S_TICK_ONE: begin
          idx <= idx + CW'(1);
          if (fire) begin
            occ[oi] <= 1'b0;
          end
        end
        tes_pkg::S_REG_RELOAD: begin
          pen[count[PIW-1:0]] <= 1'b0;
        end
        tes_pkg::S_REG_DUE: begin
          count <= count + PCW'(1);
          st    <= tes_pkg::STATUS_OK;
        end
        tes_pkg::S_ENA_WALK: begin
          idx <= idx + CW'(1);
          if (per_in && (phandle[pi] == cmd_q.handle)) begin
            pen[pi] <= cmd_q.enable;
            st      <= tes_pkg::STATUS_OK;
          end
        end
        tes_pkg::S_ONE_ADD: begin
          idx <= idx + CW'(1);
          if (os_in && !occ[oi]) begin
            occ[oi]     <= 1'b1;
            ohandle[oi] <= cmd_q.handle;
            st          <= tes_pkg::STATUS_OK;
          end
        end
        tes_pkg::S_ONE_CANCEL: begin
          idx <= idx + CW'(1);
          if (os_in && (ohandle[oi] == cmd_q.handle)) begin
            occ[oi] <= 1'b0;
            st      <= tes_pkg::STATUS_OK;
          end
        end
        default: begin
        end
      endcase
      if (record) begin
        pend_valid <= 1'b1;
        fcnt       <= fcnt + tes_pkg::FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    if (record) begin
      pend_kind   <= fire_kind;
      pend_handle <= fire_handle;
    end
    case (state)
      tes_pkg::S_TICK_PER: begin
        if (fire) begin
          pdue[pi] <= alu_rsp.sum;
        end
      end
      tes_pkg::S_REG_RELOAD: begin
        phandle[count[PIW-1:0]] <= cmd_q.handle;
        preload[count[PIW-1:0]] <= alu_rsp.sum;
      end
      tes_pkg::S_REG_DUE: begin
        pdue[count[PIW-1:0]] <= alu_rsp.sum;
      end
      tes_pkg::S_ENA_WALK: begin
        if (per_in && (phandle[pi] == cmd_q.handle) && cmd_q.enable) begin
          pdue[pi] <= alu_rsp.sum;
        end
      end
      tes_pkg::S_ONE_ADD: begin
        if (os_in && !occ[oi]) begin
          odue[oi] <= alu_rsp.sum;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.kind == tes_pkg::KIND_ACK)) |->
      (result.last && (result.fired_handle == cmd_q.handle)))
    else $error("acknowledge item is not final or carries a wrong handle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= PCW'(PERIODIC_SLOTS))
    else $error("periodic slot count exceeds the table size");

  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fcnt <= tes_pkg::FCNT_W'(tes_pkg::MAX_RESULTS))
    else $error("reported fire count exceeds the result limit");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == tes_pkg::S_IDLE) |-> !strobe)
    else $error("result issued without an item in progress");
`endif

endmodule
